@@ rtl/utf8_width_line_wrapper_assert.svh @@
// Assertion macros shared by the checker of the UTF-8 width line wrapper.
// No dependencies; included by files that carry concurrent assertions.
`ifndef UTF8_WIDTH_LINE_WRAPPER_ASSERT_SVH
`define UTF8_WIDTH_LINE_WRAPPER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UWLW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define UWLW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ rtl/uwlw_pkg.sv @@
// Shared types and decode functions for the UTF-8 width line wrapper.
// No dependencies; used by the controller, datapath and top level.
`timescale 1ns / 1ps

package uwlw_pkg;

	localparam logic [7:0] MAX_WIDTH_RESET = 8'd40;

	// controller -> datapath
	typedef struct packed {
		logic accept; // store the incoming byte
		logic step;   // decode one character from the buffer head
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic hold;     // incoming byte leaves the sequence unfinished
		logic run_done; // the character being decoded empties the buffer
	} sts_t;

	function automatic logic [2:0] seq_length(input logic [7:0] lead);
		logic [2:0] len;
		len = 3'd1;
		if (lead[7] == 1'b0)
			len = 3'd1;
		else if ((lead & 8'hE0) == 8'hC0)
			len = 3'd2;
		else if ((lead & 8'hF0) == 8'hE0)
			len = 3'd3;
		else if ((lead & 8'hF8) == 8'hF0)
			len = 3'd4;
		return len;
	endfunction

	function automatic logic [1:0] glyph_width(input logic [15:0] cp);
		logic wide;
		wide = (cp >= 16'h1100 && cp <= 16'h115F) || (cp >= 16'h2E80 && cp <= 16'hA4CF) ||
			(cp >= 16'hAC00 && cp <= 16'hD7A3) || (cp >= 16'hF900 && cp <= 16'hFAFF) ||
			(cp >= 16'hFE30 && cp <= 16'hFE4F) || (cp >= 16'hFF00 && cp <= 16'hFF60) ||
			(cp >= 16'hFFE0 && cp <= 16'hFFE6) || (cp == 16'hFFFF);
		return wide ? 2'd2 : 2'd1;
	endfunction

endpackage

@@ rtl/utf8_width_line_wrapper.sv @@
// A byte that completes a character starts a decode run, and each result is registered at
// out_valid; the byte buffer is decoded one character per cycle while the output is not stalled.
// Intake: in_ready stays high after a byte held in an unfinished sequence, and drops for a decode
// run until the buffer is empty; a string cut off mid-sequence decodes its lead as a lone byte.
// Reset (arst_n, asynchronous): buffer empty, line at column 0, line width limit = 40.
`timescale 1ns / 1ps

module utf8_width_line_wrapper (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        end_of_string,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] code_point,
	output logic [2:0]  char_bytes,
	output logic [1:0]  display_width,
	output logic        break_before,
	output logic [8:0]  column_after,
	output logic        string_done,
	output logic        last_of_run
);
	import uwlw_pkg::*;

	cmd_t cmd;
	sts_t sts;

	uwlw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	uwlw_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_byte       (in_byte),
		.end_of_string (end_of_string),
		.cmd           (cmd),
		.sts           (sts),
		.code_point    (code_point),
		.char_bytes    (char_bytes),
		.display_width (display_width),
		.break_before  (break_before),
		.column_after  (column_after),
		.string_done   (string_done),
		.last_of_run   (last_of_run)
	);

endmodule

@@ rtl/uwlw_ctrl.sv @@
// Controller of the UTF-8 width line wrapper: byte intake and decode run sequencing.
// Depends on uwlw_pkg for the command and status structs.
`timescale 1ns / 1ps

module uwlw_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  uwlw_pkg::sts_t  sts,
	output uwlw_pkg::cmd_t  cmd
);
	import uwlw_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic state_q;
	logic state_d;
	logic out_valid_q;

	assign in_ready   = (state_q == ST_IDLE);
	assign cmd.accept = in_valid && in_ready;
	// in the run state, a character is decoded whenever the output register is free or emptying
	assign cmd.step   = (state_q == ST_RUN) && (!out_valid_q || out_ready);
	assign out_valid  = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.accept && !sts.hold)
					state_d = ST_RUN;
			end
			ST_RUN: begin
				if (cmd.step && sts.run_done)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.step)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

@@ rtl/uwlw_datapath.sv @@
// Datapath of the UTF-8 width line wrapper: byte buffer, decoder, column count, result register.
// Depends on uwlw_pkg for seq_length, glyph_width and the command/status structs.
`timescale 1ns / 1ps

module uwlw_datapath (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wr_en,
	input  logic [7:0]      cfg_wr_data,
	input  logic [7:0]      in_byte,
	input  logic            end_of_string,
	input  uwlw_pkg::cmd_t  cmd,
	output uwlw_pkg::sts_t  sts,
	output logic [15:0]     code_point,
	output logic [2:0]      char_bytes,
	output logic [1:0]      display_width,
	output logic            break_before,
	output logic [8:0]      column_after,
	output logic            string_done,
	output logic            last_of_run
);
	import uwlw_pkg::*;

	logic [7:0]  buf_q [4];
	logic [2:0]  cnt_q;
	logic        last_q;
	logic [8:0]  line_q;
	logic [7:0]  maxw_q;

	logic [7:0]  lead_in;
	logic [2:0]  len_in;
	logic [2:0]  n_in;
	logic [2:0]  len_hd;
	logic        fits;
	logic [2:0]  take;
	logic [2:0]  rem;
	logic [15:0] cp;
	logic [1:0]  w;
	logic [9:0]  line_sum;
	logic        brk;
	logic [8:0]  line_new;

	logic [15:0] code_point_q;
	logic [2:0]  char_bytes_q;
	logic [1:0]  display_width_q;
	logic        break_before_q;
	logic [8:0]  column_after_q;
	logic        string_done_q;
	logic        last_of_run_q;

	// intake: does the new byte finish the sequence led by the buffer head
	assign lead_in  = (cnt_q == 3'd0) ? in_byte : buf_q[0];
	assign len_in   = seq_length(lead_in);
	assign n_in     = cnt_q + 3'd1;
	assign sts.hold = !end_of_string && (n_in < len_in);

	// decode the character at the buffer head; a cut-off lead is a lone byte
	assign len_hd = seq_length(buf_q[0]);
	assign fits   = (len_hd > 3'd1) && (len_hd <= cnt_q);
	assign take   = fits ? len_hd : 3'd1;
	assign rem    = cnt_q - take;
	assign sts.run_done = (rem == 3'd0);

	always_comb begin
		cp = {8'h00, buf_q[0]};
		if (fits) begin
			case (len_hd)
				3'd2: cp = {5'd0, buf_q[0][4:0], buf_q[1][5:0]};
				3'd3: cp = {buf_q[0][3:0], buf_q[1][5:0], buf_q[2][5:0]};
				default: cp = 16'hFFFF;
			endcase
		end
	end

	assign w        = glyph_width(cp);
	assign line_sum = {1'b0, line_q} + {8'd0, w};
	assign brk      = (line_q != 9'd0) && (line_sum > {2'b00, maxw_q});
	assign line_new = brk ? {7'd0, w} : line_sum[8:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 3'd0;
			last_q <= 1'b0;
			line_q <= 9'd0;
			maxw_q <= MAX_WIDTH_RESET;
		end else begin
			if (cfg_wr_en)
				maxw_q <= cfg_wr_data;
			if (cmd.accept) begin
				cnt_q  <= n_in;
				last_q <= end_of_string;
			end else if (cmd.step) begin
				cnt_q  <= rem;
				line_q <= (sts.run_done && last_q) ? 9'd0 : line_new;
			end
		end
	end

	// byte buffer: written at the fill count, shifted down by the consumed length
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			buf_q[cnt_q[1:0]] <= in_byte;
		end else if (cmd.step) begin
			case (take)
				3'd1: begin
					buf_q[0] <= buf_q[1];
					buf_q[1] <= buf_q[2];
					buf_q[2] <= buf_q[3];
				end
				3'd2: begin
					buf_q[0] <= buf_q[2];
					buf_q[1] <= buf_q[3];
				end
				3'd3: buf_q[0] <= buf_q[3];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			code_point_q    <= cp;
			char_bytes_q    <= take;
			display_width_q <= w;
			break_before_q  <= brk;
			column_after_q  <= line_new;
			string_done_q   <= sts.run_done && last_q;
			last_of_run_q   <= sts.run_done;
		end
	end

	assign code_point    = code_point_q;
	assign char_bytes    = char_bytes_q;
	assign display_width = display_width_q;
	assign break_before  = break_before_q;
	assign column_after  = column_after_q;
	assign string_done   = string_done_q;
	assign last_of_run   = last_of_run_q;

endmodule

@@ rtl/uwlw_checker.sv @@
// Port-level checker for the UTF-8 width line wrapper, bound to the top level.
// Depends on utf8_width_line_wrapper_assert.svh for the assertion macros.
`timescale 1ns / 1ps

module uwlw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] code_point,
	input logic [1:0]  display_width,
	input logic        break_before,
	input logic [8:0]  column_after,
	input logic        string_done,
	input logic        last_of_run
);
`include "utf8_width_line_wrapper_assert.svh"

	// a stalled result holds
	`UWLW_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(code_point))
	`UWLW_ASSERT_IMPL(a_width_range, clk, arst_n, out_valid, display_width == 2'd1 || display_width == 2'd2)
	// after a break the line holds only the new character
	`UWLW_ASSERT_IMPL(a_break_col, clk, arst_n, out_valid && break_before, column_after == {7'd0, display_width})
	`UWLW_ASSERT_IMPL(a_done_last, clk, arst_n, out_valid && string_done, last_of_run)

endmodule

bind utf8_width_line_wrapper uwlw_checker u_uwlw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.code_point    (code_point),
	.display_width (display_width),
	.break_before  (break_before),
	.column_after  (column_after),
	.string_done   (string_done),
	.last_of_run   (last_of_run)
);

@@ sim/tb_top.sv @@
// Self-checking testbench for utf8_width_line_wrapper: drives UTF-8 text bytes,
// predicts each decoded character and its line break, and compares every result.
// Depends on uwlw_pkg and the utf8_width_line_wrapper RTL.
`timescale 1ns / 1ps

module tb_top;

	typedef struct packed {
		logic [15:0] code_point;
		logic [2:0]  char_bytes;
		logic [1:0]  display_width;
		logic        break_before;
		logic [8:0]  column_after;
		logic        string_done;
		logic        last_of_run;
	} wrapped_char_t;

	typedef enum int {
		KIND_ASCII,
		KIND_TWO_BYTE,
		KIND_THREE_BYTE,
		KIND_FOUR_BYTE,
		KIND_STRAY,
		KIND_BOUNDARY
	} char_kind_t;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SETTLE_CYCLES  = 4;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [7:0]  cfg_wr_data;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  in_byte;
	logic        end_of_string;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] code_point;
	logic [2:0]  char_bytes;
	logic [1:0]  display_width;
	logic        break_before;
	logic [8:0]  column_after;
	logic        string_done;
	logic        last_of_run;

	// predictor state
	logic [7:0]  held_bytes [0:2];
	int          held_count;
	logic [8:0]  line_cols;
	logic [7:0]  width_limit;

	wrapped_char_t expected_chars [$];
	wrapped_char_t next_char;
	int          mismatch_count;
	int          bytes_sent;
	int          stall_left;
	int          quiet_cycles;
	logic        idle_on;

	// code points at the edges of the wide ranges
	logic [15:0] boundary_cps [0:29] = '{
		16'h10FF, 16'h1100, 16'h115F, 16'h1160, 16'h2E7F, 16'h2E80, 16'hA4CF, 16'hA4D0,
		16'hABFF, 16'hAC00, 16'hD7A3, 16'hD7A4, 16'hF8FF, 16'hF900, 16'hFAFF, 16'hFB00,
		16'hFE2F, 16'hFE30, 16'hFE4F, 16'hFE50, 16'hFEFF, 16'hFF00, 16'hFF60, 16'hFF61,
		16'hFFDF, 16'hFFE0, 16'hFFE6, 16'hFFE7, 16'hFFFE, 16'hFFFF
	};

	utf8_width_line_wrapper DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.end_of_string(end_of_string),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.code_point(code_point),
		.char_bytes(char_bytes),
		.display_width(display_width),
		.break_before(break_before),
		.column_after(column_after),
		.string_done(string_done),
		.last_of_run(last_of_run)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int lead_length(input logic [7:0] lead);
		casez (lead)
			8'b0???????: return 1;
			8'b110?????: return 2;
			8'b1110????: return 3;
			8'b11110???: return 4;
			default:     return 1;
		endcase
	endfunction

	function automatic logic [1:0] columns_of(input logic [15:0] cp);
		logic wide;
		wide = 1'b0;
		if (cp >= 16'h1100 && cp <= 16'h115F) wide = 1'b1;
		if (cp >= 16'h2E80 && cp <= 16'hA4CF) wide = 1'b1;
		if (cp >= 16'hAC00 && cp <= 16'hD7A3) wide = 1'b1;
		if (cp >= 16'hF900 && cp <= 16'hFAFF) wide = 1'b1;
		if (cp >= 16'hFE30 && cp <= 16'hFE4F) wide = 1'b1;
		if (cp >= 16'hFF00 && cp <= 16'hFF60) wide = 1'b1;
		if (cp >= 16'hFFE0 && cp <= 16'hFFE6) wide = 1'b1;
		if (cp == 16'hFFFF) wide = 1'b1;
		return wide ? 2'd2 : 2'd1;
	endfunction

	// Decode the accepted byte together with any held bytes and queue the characters.
	function automatic void predict_wrap(input logic [7:0] b, input logic eos);
		logic [7:0]    run_bytes [0:3];
		wrapped_char_t chars [0:3];
		int            n;
		int            p;
		int            len;
		int            produced;
		logic [15:0]   cp;
		logic [1:0]    w;
		logic          brk;
		for (int i = 0; i < held_count; i++)
			run_bytes[i] = held_bytes[i];
		run_bytes[held_count] = b;
		n = held_count + 1;
		len = lead_length(run_bytes[0]);
		if (!eos && n < len) begin
			for (int i = 0; i < n; i++)
				held_bytes[i] = run_bytes[i];
			held_count = n;
			return;
		end
		produced = 0;
		p = 0;
		while (p < n) begin
			len = lead_length(run_bytes[p]);
			cp = {8'h00, run_bytes[p]};
			if (len > 1 && p + len <= n) begin
				if (len == 2)
					cp = {5'b0, run_bytes[p][4:0], run_bytes[p + 1][5:0]};
				else if (len == 3)
					cp = {run_bytes[p][3:0], run_bytes[p + 1][5:0], run_bytes[p + 2][5:0]};
				else
					cp = 16'hFFFF;
			end else begin
				// sequence cut off by the end of the string: lead stands alone
				len = 1;
			end
			w = columns_of(cp);
			brk = (line_cols != 9'd0) && (int'(line_cols) + int'(w) > int'(width_limit));
			line_cols = brk ? {7'b0, w} : line_cols + {7'b0, w};
			chars[produced] = '{cp, 3'(len), w, brk, line_cols, 1'b0, 1'b0};
			produced++;
			p += len;
		end
		chars[produced - 1].string_done = eos;
		chars[produced - 1].last_of_run = 1'b1;
		for (int i = 0; i < produced; i++)
			expected_chars = {expected_chars, chars[i]};
		held_count = 0;
		if (eos)
			line_cols = 9'd0;
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t ERROR %s: expected %0h, actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	// Valid stays high after acceptance; the next call either reloads the payload
	// or lowers it for an idle burst.
	task automatic send_byte(input logic [7:0] b, input logic eos);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		end_of_string <= eos;
		do @(posedge clk); while (in_ready !== 1'b1);
		predict_wrap(b, eos);
		bytes_sent++;
	endtask

	task automatic set_line_width(input logic [7:0] w);
		in_valid <= 1'b0;
		while (expected_chars.size() != 0) @(posedge clk);
		// a held byte gives no result but may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= w;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		width_limit = w;
	endtask

	function automatic logic [7:0] cont_byte();
		// mostly proper continuation bytes, sometimes anything
		if ($urandom_range(0, 7) == 0)
			return 8'($urandom_range(0, 255));
		return {2'b10, 6'($urandom_range(0, 63))};
	endfunction

	task automatic send_random_text(input int max_chars);
		logic [7:0]  text [$];
		logic [15:0] cp;
		char_kind_t  kind;
		int          nchars;
		int          last_len;
		int          roll;
		nchars = $urandom_range(1, max_chars);
		last_len = 1;
		for (int c = 0; c < nchars; c++) begin
			roll = $urandom_range(0, 9);
			case (roll)
				0, 1, 2: kind = KIND_ASCII;
				3:       kind = KIND_TWO_BYTE;
				4, 5:    kind = KIND_THREE_BYTE;
				6:       kind = KIND_FOUR_BYTE;
				7:       kind = KIND_STRAY;
				default: kind = KIND_BOUNDARY;
			endcase
			case (kind)
				KIND_ASCII: begin
					text = {text, {1'b0, 7'($urandom_range(0, 127))}};
					last_len = 1;
				end
				KIND_TWO_BYTE: begin
					text = {text, {3'b110, 5'($urandom_range(0, 31))}};
					text = {text, cont_byte()};
					last_len = 2;
				end
				KIND_THREE_BYTE: begin
					text = {text, {4'b1110, 4'($urandom_range(0, 15))}};
					text = {text, cont_byte()};
					text = {text, cont_byte()};
					last_len = 3;
				end
				KIND_FOUR_BYTE: begin
					text = {text, {5'b11110, 3'($urandom_range(0, 7))}};
					text = {text, cont_byte()};
					text = {text, cont_byte()};
					text = {text, cont_byte()};
					last_len = 4;
				end
				KIND_STRAY: begin
					if ($urandom_range(0, 1) == 0)
						text = {text, {2'b10, 6'($urandom_range(0, 63))}};
					else
						text = {text, {5'b11111, 3'($urandom_range(0, 7))}};
					last_len = 1;
				end
				default: begin
					cp = boundary_cps[$urandom_range(0, 29)];
					text = {text, {4'hE, cp[15:12]}};
					text = {text, {2'b10, cp[11:6]}};
					text = {text, {2'b10, cp[5:0]}};
					last_len = 3;
				end
			endcase
		end
		// now and then cut the string inside its last character
		if (last_len > 1 && $urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, last_len - 1)) void'(text.pop_back());
		for (int i = 0; i < text.size(); i++)
			send_byte(text[i], i == text.size() - 1);
	endtask

	task automatic run_text_phase(input int byte_budget, input int max_chars);
		int target;
		target = bytes_sent + byte_budget;
		while (bytes_sent < target)
			send_random_text(max_chars);
	endtask

	// Sequences of each length, plus stray bytes, at the reset width.
	task automatic test_encodings();
		logic [8:0] seq [0:18];
		seq = '{9'h000, 9'h17F,
			9'h0C2, 9'h0A9, 9'h0DF, 9'h1BF,
			9'h0E1, 9'h084, 9'h080, 9'h0EF, 9'h0BF, 9'h1BF,
			9'h0F0, 9'h09F, 9'h098, 9'h180,
			9'h080, 9'h0F8, 9'h1FF};
		for (int i = 0; i < 19; i++)
			send_byte(seq[i][7:0], seq[i][8]);
	endtask

	// Strings that end before their last sequence is complete.
	task automatic test_truncated_strings();
		logic [8:0] seq [0:5];
		seq = '{9'h0F0, 9'h09F, 9'h198,
			9'h0E4, 9'h1B8,
			9'h1C3};
		for (int i = 0; i < 6; i++)
			send_byte(seq[i][7:0], seq[i][8]);
	endtask

	task automatic test_width_sweep();
		set_line_width(8'd1);
		run_text_phase(40, 10);
		set_line_width(8'd0);
		run_text_phase(30, 8);
		set_line_width(8'd255);
		run_text_phase(30, 40);
		set_line_width(8'd2);
		run_text_phase(40, 10);
		set_line_width(8'($urandom_range(3, 30)));
		run_text_phase(50, 20);
	endtask

	task automatic test_steady_stream();
		set_line_width(uwlw_pkg::MAX_WIDTH_RESET);
		idle_on = 1'b0;
		run_text_phase(60, 30);
	endtask

	always @(posedge clk) begin
		if (!idle_on) begin
			stall_left = 0;
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 9);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (expected_chars.size() == 0) begin
				$display("%0t ERROR unexpected item: expected none, actual code_point %0h",
					$time, code_point);
				mismatch_count++;
			end else begin
				next_char = expected_chars.pop_front();
				check_field("code_point", next_char.code_point, code_point);
				check_field("char_bytes", 16'(next_char.char_bytes), 16'(char_bytes));
				check_field("display_width", 16'(next_char.display_width),
					16'(display_width));
				check_field("break_before", 16'(next_char.break_before), 16'(break_before));
				check_field("column_after", 16'(next_char.column_after), 16'(column_after));
				check_field("string_done", 16'(next_char.string_done), 16'(string_done));
				check_field("last_of_run", 16'(next_char.last_of_run), 16'(last_of_run));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid === 1'b1 && in_ready === 1'b1) ||
				(out_valid === 1'b1 && out_ready === 1'b1)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t ERROR watchdog: no item moved for %0d cycles", $time,
					quiet_cycles);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 8'd0;
		in_valid = 1'b0;
		in_byte = 8'd0;
		end_of_string = 1'b0;
		out_ready = 1'b0;
		idle_on = 1'b1;
		stall_left = 0;
		quiet_cycles = 0;
		mismatch_count = 0;
		bytes_sent = 0;
		held_count = 0;
		line_cols = 9'd0;
		width_limit = uwlw_pkg::MAX_WIDTH_RESET;
		for (int i = 0; i < 3; i++)
			held_bytes[i] = 8'd0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_encodings();
		test_truncated_strings();
		test_width_sweep();
		test_steady_stream();
		in_valid <= 1'b0;
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/uwlw_pkg.sv
rtl/uwlw_ctrl.sv
rtl/uwlw_datapath.sv
rtl/utf8_width_line_wrapper.sv
rtl/uwlw_checker.sv
sim/tb_top.sv
